// ----- src/rfsc_pkg.sv -----
`default_nettype none

package rfsc_pkg;

    localparam int unsigned MAX_FRAME = 32;

    localparam int unsigned CMD_W  = 8;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned SKIP_W = 8;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SKIP         = 2'd2;

    localparam logic [CMD_W-1:0]  RST_EXPECTED_COMMAND = 8'd1;
    localparam logic [LEN_W-1:0]  RST_FRAME_LENGTH     = 6'd23;
    localparam logic [SKIP_W-1:0] RST_MAX_SKIP         = 8'd100;

    localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(MAX_FRAME);

    typedef struct packed {
        logic [CMD_W-1:0]  expected_command;
        logic [LEN_W-1:0]  frame_length;
        logic [SKIP_W-1:0] max_skip;
    } rfsc_cfg_t;

    typedef struct packed {
        logic              checksum_ok;
        logic              frame_end;
        logic              header_forced;
        logic [POS_W-1:0]  byte_position;
        logic              in_frame;
        logic [7:0]        data_byte;
    } rfsc_result_t;

endpackage

`default_nettype wire

// ----- src/reply_frame_sync_checksum.sv -----
// Channel  | Signals                          | Contents
// ---------+----------------------------------+-------------------------------------------
// input    | s_tvalid s_tready s_tdata        | received byte
// output   | m_tvalid m_tready m_tdata m_tuser| result for each byte, m_tlast = frame end
// config   | cfg_we cfg_index cfg_data        | expected command, frame length, skip limit
//
// Each byte takes one transfer in and yields one transfer out, through the input register and then the result register.
// The sustained rate is one byte per cycle while the output is not stalled, set by the framer's per-byte update.
// Reset empties the input and output registers and starts a hunt for a header.
// A stall on the output holds the result register; the input register then fills
// and further input transfers wait until the output is taken.
`default_nettype none

module reply_frame_sync_checksum
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] rx_byte
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [15:0]                         m_tdata,   // [7:0] data_byte,
                                                                // [12:8] byte_position,
                                                                // [13] checksum_ok
    output      logic [1:0]                          m_tuser,   // [0] in_frame,
                                                                // [1] header_forced
    output      logic                                m_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [rfsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rfsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rfsc_pkg::rfsc_cfg_t    cfg;
    rfsc_pkg::rfsc_result_t result;
    rfsc_pkg::rfsc_result_t out_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    rfsc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfsc_framer u_framer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .byte_in (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.checksum_ok, out_reg.byte_position, out_reg.data_byte};
    assign m_tuser  = {out_reg.header_forced, out_reg.in_frame};
    assign m_tlast  = out_reg.frame_end;

endmodule

`default_nettype wire

// ----- src/rfsc_cfg_regs.sv -----
`default_nettype none

module rfsc_cfg_regs
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rfsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rfsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rfsc_pkg::rfsc_cfg_t                      cfg
);

    rfsc_pkg::rfsc_cfg_t cfg_reg;
    rfsc_pkg::rfsc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rfsc_pkg::REG_EXPECTED_COMMAND:
                    cfg_next.expected_command = cfg_data[rfsc_pkg::CMD_W-1:0];
                rfsc_pkg::REG_FRAME_LENGTH:
                    cfg_next.frame_length = cfg_data[rfsc_pkg::LEN_W-1:0];
                rfsc_pkg::REG_MAX_SKIP:
                    cfg_next.max_skip = cfg_data[rfsc_pkg::SKIP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_command <= rfsc_pkg::RST_EXPECTED_COMMAND;
            cfg_reg.frame_length     <= rfsc_pkg::RST_FRAME_LENGTH;
            cfg_reg.max_skip         <= rfsc_pkg::RST_MAX_SKIP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/rfsc_framer.sv -----
`default_nettype none

module rfsc_framer
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  rfsc_pkg::rfsc_cfg_t    cfg,
    input  wire logic              advance,
    input  wire logic [7:0]        byte_in,
    output rfsc_pkg::rfsc_result_t result
);

    logic                          hunting_reg;
    logic                          hunting_next;
    logic [rfsc_pkg::SKIP_W-1:0]   skip_reg;
    logic [rfsc_pkg::SKIP_W-1:0]   skip_next;
    logic [rfsc_pkg::POS_W-1:0]    pos_reg;
    logic [rfsc_pkg::POS_W-1:0]    pos_next;
    logic [rfsc_pkg::SUM_W-1:0]    sum_reg;
    logic [rfsc_pkg::SUM_W-1:0]    sum_next;
    logic [7:0]                    high_reg;
    logic [7:0]                    high_next;

    logic [rfsc_pkg::LEN_W-1:0]    len;
    logic [rfsc_pkg::SKIP_W-1:0]   limit;
    logic [rfsc_pkg::SKIP_W:0]     seen;
    logic [rfsc_pkg::LEN_W-1:0]    pos_plus1;
    logic [rfsc_pkg::LEN_W-1:0]    pos_plus2;
    logic                          match;

    assign len   = (cfg.frame_length > rfsc_pkg::MAX_FRAME_LEN) ?
                   rfsc_pkg::MAX_FRAME_LEN : cfg.frame_length;
    assign limit = (cfg.max_skip == '0) ? rfsc_pkg::SKIP_W'(1) : cfg.max_skip;
    assign seen  = {1'b0, skip_reg} + (rfsc_pkg::SKIP_W+1)'(1);
    assign match = (byte_in == cfg.expected_command);
    assign pos_plus1 = {1'b0, pos_reg} + rfsc_pkg::LEN_W'(1);
    assign pos_plus2 = {1'b0, pos_reg} + rfsc_pkg::LEN_W'(2);

    always_comb
    begin
        hunting_next = hunting_reg;
        skip_next    = skip_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        high_next    = high_reg;

        result               = '0;
        result.data_byte     = byte_in;

        if (hunting_reg)
        begin
            if (match || (seen >= {1'b0, limit}))
            begin
                result.in_frame      = 1'b1;
                result.header_forced = !match;
                skip_next = '0;
                sum_next  = {8'd0, byte_in};
                high_next = '0;
                if (len <= rfsc_pkg::LEN_W'(1))
                begin
                    result.frame_end = 1'b1;
                    pos_next = '0;
                end
                else
                begin
                    hunting_next = 1'b0;
                    pos_next = rfsc_pkg::POS_W'(1);
                end
            end
            else
            begin
                skip_next = seen[rfsc_pkg::SKIP_W-1:0];
            end
        end
        else
        begin
            result.in_frame      = 1'b1;
            result.byte_position = pos_reg;
            if (pos_plus1 >= len)
            begin
                // Trailing byte: compare the sum with the held high byte and this one.
                result.frame_end   = 1'b1;
                result.checksum_ok = (len >= rfsc_pkg::LEN_W'(4)) &&
                                     (sum_reg == {high_reg, byte_in});
                hunting_next = 1'b1;
                pos_next     = '0;
                skip_next    = '0;
            end
            else
            begin
                if (pos_reg[0] && (pos_plus2 < len))
                begin
                    high_next = byte_in;
                end
                else if (!pos_reg[0] && (pos_plus2 <= len))
                begin
                    sum_next = sum_reg + {high_reg, byte_in};
                end
                if (pos_plus2 == len)
                begin
                    high_next = byte_in;
                end
                pos_next = pos_plus1[rfsc_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            skip_reg    <= '0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            high_reg    <= '0;
        end
        else if (advance)
        begin
            hunting_reg <= hunting_next;
            skip_reg    <= skip_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            high_reg    <= high_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        hunting_reg |-> (pos_reg == '0))
        else $error("Position is not zero while hunting.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !hunting_reg |-> (pos_reg != '0))
        else $error("Position is zero inside a frame.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.frame_end) |=> hunting_reg)
        else $error("Hunt did not resume after the end of a frame.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hunting_reg && result.in_frame) |=> (skip_reg == '0))
        else $error("Skip count was not cleared when a header was taken.");

endmodule

`default_nettype wire
